FILE: rtl/passage_wall_splay_vectors_unit_macros.svh
// Assertion macros for the passage wall splay vectors unit.
// Used by the queue, the scaling lanes and the back end; needs clk and rst_n in scope.
`ifndef PASSAGE_WALL_SPLAY_VECTORS_UNIT_MACROS_SVH
`define PASSAGE_WALL_SPLAY_VECTORS_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PWSV_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("pwsv assertion failed");
`define PWSV_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("pwsv assertion failed");
`else
`define PWSV_ASSERT_IMP(lbl, pre, post)
`define PWSV_ASSERT_NXT(lbl, pre, post)
`endif
`endif

FILE: rtl/pwsv_pkg.sv
// Shared constants and types for the passage wall splay vectors unit.
// No dependencies.
`timescale 1ns / 1ps

package pwsv_pkg;

    localparam int DirW   = 20;
    localparam int MagW   = 20;
    localparam int DistW  = 16;
    localparam int SqW    = 2 * MagW;
    localparam int OutW   = 17;
    localparam int KindW  = 2;

    localparam int FifoDepth = 2;
    localparam int FifoIdxW  = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
    localparam int FifoCntW  = $clog2(FifoDepth + 1);

    localparam int RootBits = DistW;
    localparam int StepW    = $clog2(RootBits);

    localparam logic [KindW-1:0] KIND_UP    = 2'd0;
    localparam logic [KindW-1:0] KIND_DOWN  = 2'd1;
    localparam logic [KindW-1:0] KIND_LEFT  = 2'd2;
    localparam logic [KindW-1:0] KIND_RIGHT = 2'd3;

    // classified request as it sits in the queue
    typedef struct packed {
        logic [MagW-1:0]  ax;
        logic [MagW-1:0]  ay;
        logic [SqW-1:0]   sq;
        logic             zero;
        logic             lx_neg;
        logic             ly_neg;
        logic             rx_neg;
        logic             ry_neg;
        logic [DistW-1:0] up;
        logic [DistW-1:0] down;
        logic [DistW-1:0] left;
        logic [DistW-1:0] right;
    } item_t;

    typedef struct packed {
        logic start;
        logic ack;
    } lane_ctl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

FILE: rtl/pwsv_item_if.sv
// Input channel of the splay vectors unit: one survey request per handshake.
// Depends on pwsv_pkg.
`timescale 1ns / 1ps

interface pwsv_item_if;
    logic                             valid;
    logic                             ready;
    logic signed [pwsv_pkg::DirW-1:0] dir_x;
    logic signed [pwsv_pkg::DirW-1:0] dir_y;
    logic                             from_missing;
    logic [pwsv_pkg::DistW-1:0]       dist_up;
    logic [pwsv_pkg::DistW-1:0]       dist_down;
    logic [pwsv_pkg::DistW-1:0]       dist_left;
    logic [pwsv_pkg::DistW-1:0]       dist_right;

    modport source (output valid, dir_x, dir_y, from_missing, dist_up, dist_down,
                    dist_left, dist_right, input ready);
    modport sink (input valid, dir_x, dir_y, from_missing, dist_up, dist_down,
                  dist_left, dist_right, output ready);
endinterface

FILE: rtl/pwsv_splay_if.sv
// Output channel of the splay vectors unit: one splay vector per handshake.
// Depends on pwsv_pkg.
`timescale 1ns / 1ps

interface pwsv_splay_if;
    logic                             valid;
    logic                             ready;
    logic signed [pwsv_pkg::OutW-1:0] splay_x;
    logic signed [pwsv_pkg::OutW-1:0] splay_y;
    logic signed [pwsv_pkg::OutW-1:0] splay_z;
    logic [pwsv_pkg::KindW-1:0]       splay_kind;
    logic                             zero_direction;
    logic                             last;

    modport source (output valid, splay_x, splay_y, splay_z, splay_kind, zero_direction,
                    last, input ready);
    modport sink (input valid, splay_x, splay_y, splay_z, splay_kind, zero_direction,
                  last, output ready);
endinterface

FILE: rtl/passage_wall_splay_vectors_unit.sv
// A request passes the front stage, the queue and the scaling lanes before its first
// splay is valid. The lanes take a new request only when done with the last one, so
// the 16-step root search in the scaling lanes sets the request rate; the four splays
// leave one per cycle from the result buffer meanwhile, while the splay sink is ready.
// The two-entry queue lets the front take requests while the lanes are busy.
// Reset (rst_n, async, active low) empties the queue and buffer and idles the lanes.
`timescale 1ns / 1ps

module passage_wall_splay_vectors_unit (
    input  logic         clk,
    input  logic         rst_n,
    pwsv_item_if.sink    item,
    pwsv_splay_if.source splay
);
    // front -> queue
    logic                 push;
    pwsv_pkg::item_t      wdata;
    // queue -> back
    logic                 pop;
    pwsv_pkg::item_t      rdata;
    pwsv_pkg::fifo_stat_t stat;

    // Front: reversal, magnitudes, signs and x^2+y^2 per request.
    pwsv_front u_front (
        .clk,
        .rst_n,
        .item,
        .stat,
        .push,
        .wdata
    );

    // Decouples classification from the long scaling work.
    pwsv_fifo u_fifo (
        .clk,
        .rst_n,
        .push,
        .wdata,
        .pop,
        .rdata,
        .stat
    );

    // Back: four lanes compute left/right components; the result buffer
    // sends up, down, left, right in order with last on the fourth.
    pwsv_back u_back (
        .clk,
        .rst_n,
        .rdata,
        .stat,
        .pop,
        .splay
    );

endmodule

FILE: rtl/pwsv_lane.sv
// One scaling lane: round(dist * comp / sqrt(sq)) by a 16-step root search
// built from shifts and adds. Depends on pwsv_pkg and the macro header.
`timescale 1ns / 1ps
`include "passage_wall_splay_vectors_unit_macros.svh"

module pwsv_lane (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pwsv_pkg::lane_ctl_t           ctl,
    input  logic [pwsv_pkg::DistW-1:0]    span,
    input  logic [pwsv_pkg::MagW-1:0]     comp,
    input  logic [pwsv_pkg::SqW-1:0]      sq,
    output logic                          done,
    output logic [pwsv_pkg::RootBits-1:0] root
);
    localparam int ProdW  = pwsv_pkg::DistW + pwsv_pkg::MagW;
    localparam int HalfW  = ProdW / 2;
    localparam int HiW    = ProdW - HalfW;
    localparam int KW     = 2 * ProdW + 2;
    localparam int SW     = KW;
    localparam int PW     = pwsv_pkg::RootBits + 2 + pwsv_pkg::SqW;
    localparam int TrialW = SW + 4;

    typedef enum logic [2:0] {L_IDLE, L_PROD, L_PART, L_SUM, L_ITER, L_DONE} lstate_t;

    lstate_t                        state_reg;
    logic [pwsv_pkg::DistW-1:0]     dist_reg;
    logic [pwsv_pkg::MagW-1:0]      comp_reg;
    logic [pwsv_pkg::SqW-1:0]       sq_reg;
    logic [ProdW-1:0]               prod_reg;
    logic [2*HiW-1:0]               hh_reg;
    logic [HiW+HalfW-1:0]           hl_reg;
    logic [2*HalfW-1:0]             ll_reg;
    logic [KW-1:0]                  k_reg;
    logic [SW-1:0]                  s_reg;
    logic signed [PW-1:0]           p_reg;
    logic [pwsv_pkg::RootBits-1:0]  v_reg;
    logic [pwsv_pkg::StepW-1:0]     bit_reg;

    logic [pwsv_pkg::StepW:0]       sh_p;
    logic [pwsv_pkg::StepW:0]       sh_n;
    logic [pwsv_pkg::StepW+1:0]     sh_q;
    logic signed [TrialW-1:0]       s_ext;
    logic signed [TrialW-1:0]       p_ext;
    logic signed [TrialW-1:0]       q_ext;
    logic signed [TrialW-1:0]       trial;
    logic signed [PW-1:0]           p_step;
    logic                           fits;

    // trial bit b: w grows by 2^(b+1), so w^2*sq grows by P<<(b+2) + sq<<(2b+2)
    always_comb
    begin
        sh_n   = {1'b0, bit_reg} + (pwsv_pkg::StepW+1)'(1);
        sh_p   = {1'b0, bit_reg} + (pwsv_pkg::StepW+1)'(2);
        sh_q   = {1'b0, bit_reg, 1'b0} + (pwsv_pkg::StepW+2)'(2);
        s_ext  = {{(TrialW-SW){1'b0}}, s_reg};
        p_ext  = TrialW'(p_reg);
        q_ext  = {{(TrialW-pwsv_pkg::SqW){1'b0}}, sq_reg} << sh_q;
        trial  = s_ext + (p_ext <<< sh_p) + q_ext;
        fits   = (trial[SW-1:0] <= k_reg);
        p_step = p_reg + ({{(PW-pwsv_pkg::SqW){1'b0}}, sq_reg} << sh_n);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            dist_reg  <= '0;
            comp_reg  <= '0;
            sq_reg    <= '0;
            prod_reg  <= '0;
            hh_reg    <= '0;
            hl_reg    <= '0;
            ll_reg    <= '0;
            k_reg     <= '0;
            s_reg     <= '0;
            p_reg     <= '0;
            v_reg     <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                L_IDLE:
                begin
                    if (ctl.start)
                    begin
                        dist_reg  <= span;
                        comp_reg  <= comp;
                        sq_reg    <= sq;
                        state_reg <= L_PROD;
                    end
                end
                L_PROD:
                begin
                    prod_reg  <= ProdW'(dist_reg) * ProdW'(comp_reg);
                    state_reg <= L_PART;
                end
                L_PART:
                begin
                    hh_reg    <= (2*HiW)'(prod_reg[ProdW-1:HalfW]) *
                                 (2*HiW)'(prod_reg[ProdW-1:HalfW]);
                    hl_reg    <= (HiW+HalfW)'(prod_reg[ProdW-1:HalfW]) *
                                 (HiW+HalfW)'(prod_reg[HalfW-1:0]);
                    ll_reg    <= (2*HalfW)'(prod_reg[HalfW-1:0]) *
                                 (2*HalfW)'(prod_reg[HalfW-1:0]);
                    state_reg <= L_SUM;
                end
                L_SUM:
                begin
                    // 4*prod^2 from the three partial products
                    k_reg     <= (KW'(hh_reg) << (2*HalfW + 2)) +
                                 (KW'(hl_reg) << (HalfW + 3)) +
                                 (KW'(ll_reg) << 2);
                    s_reg     <= SW'(sq_reg);
                    p_reg     <= -$signed({{(PW-pwsv_pkg::SqW){1'b0}}, sq_reg});
                    v_reg     <= '0;
                    bit_reg   <= pwsv_pkg::StepW'(pwsv_pkg::RootBits - 1);
                    state_reg <= L_ITER;
                end
                L_ITER:
                begin
                    if (fits)
                    begin
                        s_reg <= trial[SW-1:0];
                        p_reg <= p_step;
                        v_reg <= v_reg | (pwsv_pkg::RootBits'(1) << bit_reg);
                    end
                    if (bit_reg == '0)
                        state_reg <= L_DONE;
                    else
                        bit_reg <= bit_reg - pwsv_pkg::StepW'(1);
                end
                L_DONE:
                begin
                    if (ctl.ack)
                        state_reg <= L_IDLE;
                end
                default:
                    state_reg <= L_IDLE;
            endcase
        end
    end

    assign done = (state_reg == L_DONE);
    assign root = v_reg;

    // a zero direction gives no bound on the search; the back end discards it
    `PWSV_ASSERT_IMP(a_root_bound, state_reg == L_DONE && sq_reg != '0, v_reg <= dist_reg)
    `PWSV_ASSERT_NXT(a_iter_end, state_reg == L_ITER && bit_reg == '0, state_reg == L_DONE)

endmodule

FILE: rtl/pwsv_fifo.sv
// Short request queue between the front and back ends.
// Depends on pwsv_pkg and the macro header.
`timescale 1ns / 1ps
`include "passage_wall_splay_vectors_unit_macros.svh"

module pwsv_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  pwsv_pkg::item_t      wdata,
    input  logic                 pop,
    output pwsv_pkg::item_t      rdata,
    output pwsv_pkg::fifo_stat_t stat
);
    pwsv_pkg::item_t                mem [pwsv_pkg::FifoDepth];
    logic [pwsv_pkg::FifoIdxW-1:0]  wr_ptr_reg;
    logic [pwsv_pkg::FifoIdxW-1:0]  rd_ptr_reg;
    logic [pwsv_pkg::FifoCntW-1:0]  count_reg;

    function automatic logic [pwsv_pkg::FifoIdxW-1:0] bump(
        input logic [pwsv_pkg::FifoIdxW-1:0] p);
        if (p == pwsv_pkg::FifoIdxW'(pwsv_pkg::FifoDepth - 1))
            return '0;
        return p + pwsv_pkg::FifoIdxW'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + pwsv_pkg::FifoCntW'(1);
            else if (pop && !push)
                count_reg <= count_reg - pwsv_pkg::FifoCntW'(1);
        end
    end

    assign rdata      = mem[rd_ptr_reg];
    assign stat.full  = (count_reg == pwsv_pkg::FifoCntW'(pwsv_pkg::FifoDepth));
    assign stat.empty = (count_reg == '0);

    `PWSV_ASSERT_IMP(a_push_room, push, !stat.full)
    `PWSV_ASSERT_IMP(a_pop_data, pop, !stat.empty)

endmodule

FILE: rtl/pwsv_front.sv
// Front end: takes requests, applies the reversal, splits sign and magnitude,
// forms x^2+y^2 and queues the request. Depends on pwsv_pkg and pwsv_item_if.
`timescale 1ns / 1ps

module pwsv_front (
    input  logic                 clk,
    input  logic                 rst_n,
    pwsv_item_if.sink            item,
    input  pwsv_pkg::fifo_stat_t stat,
    output logic                 push,
    output pwsv_pkg::item_t      wdata
);
    logic                           s1_valid_reg;
    logic [pwsv_pkg::MagW-1:0]      ax_reg;
    logic [pwsv_pkg::MagW-1:0]      ay_reg;
    logic [3:0]                     neg_reg;
    logic [pwsv_pkg::DistW-1:0]     up_reg;
    logic [pwsv_pkg::DistW-1:0]     down_reg;
    logic [pwsv_pkg::DistW-1:0]     left_reg;
    logic [pwsv_pkg::DistW-1:0]     right_reg;

    logic signed [pwsv_pkg::DirW:0] sx;
    logic signed [pwsv_pkg::DirW:0] sy;
    logic signed [pwsv_pkg::DirW:0] nx;
    logic signed [pwsv_pkg::DirW:0] ny;
    logic signed [pwsv_pkg::DirW:0] mx;
    logic signed [pwsv_pkg::DirW:0] my;
    logic                           accept;

    always_comb
    begin
        sx = (pwsv_pkg::DirW+1)'(item.dir_x);
        sy = (pwsv_pkg::DirW+1)'(item.dir_y);
        nx = item.from_missing ? -sx : sx;
        ny = item.from_missing ? -sy : sy;
        mx = (nx < 0) ? -nx : nx;
        my = (ny < 0) ? -ny : ny;
    end

    assign item.ready = !s1_valid_reg || !stat.full;
    assign accept     = item.valid && item.ready;
    assign push       = s1_valid_reg && !stat.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            ax_reg       <= '0;
            ay_reg       <= '0;
            neg_reg      <= '0;
            up_reg       <= '0;
            down_reg     <= '0;
            left_reg     <= '0;
            right_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                ax_reg       <= mx[pwsv_pkg::MagW-1:0];
                ay_reg       <= my[pwsv_pkg::MagW-1:0];
                // left x, left y, right x, right y sign
                neg_reg      <= {ny > 0, nx < 0, ny < 0, nx > 0};
                up_reg       <= item.dist_up;
                down_reg     <= item.dist_down;
                left_reg     <= item.dist_left;
                right_reg    <= item.dist_right;
            end
            else if (push)
                s1_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        wdata.ax     = ax_reg;
        wdata.ay     = ay_reg;
        wdata.sq     = pwsv_pkg::SqW'(ax_reg) * pwsv_pkg::SqW'(ax_reg) +
                       pwsv_pkg::SqW'(ay_reg) * pwsv_pkg::SqW'(ay_reg);
        wdata.zero   = (ax_reg == '0) && (ay_reg == '0);
        wdata.lx_neg = neg_reg[3];
        wdata.ly_neg = neg_reg[2];
        wdata.rx_neg = neg_reg[1];
        wdata.ry_neg = neg_reg[0];
        wdata.up     = up_reg;
        wdata.down   = down_reg;
        wdata.left   = left_reg;
        wdata.right  = right_reg;
    end

endmodule

FILE: rtl/pwsv_back.sv
// Back end: four scaling lanes work on one request while the result
// buffer hands out the previous request's four splays.
// Depends on pwsv_pkg, pwsv_lane, pwsv_splay_if and the macro header.
`timescale 1ns / 1ps
`include "passage_wall_splay_vectors_unit_macros.svh"

module pwsv_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pwsv_pkg::item_t      rdata,
    input  pwsv_pkg::fifo_stat_t stat,
    output logic                 pop,
    pwsv_splay_if.source         splay
);
    typedef enum logic {B_IDLE, B_RUN} bstate_t;

    bstate_t                        state_reg;
    logic [3:0]                     neg_reg;
    logic                           zero_reg;
    logic [pwsv_pkg::DistW-1:0]     up_reg;
    logic [pwsv_pkg::DistW-1:0]     down_reg;

    logic                           rb_valid_reg;
    logic [1:0]                     rb_cnt_reg;
    logic                           rb_zero_reg;
    logic [pwsv_pkg::DistW-1:0]     rb_up_reg;
    logic [pwsv_pkg::DistW-1:0]     rb_down_reg;
    logic signed [pwsv_pkg::OutW-1:0] rb_lx_reg;
    logic signed [pwsv_pkg::OutW-1:0] rb_ly_reg;
    logic signed [pwsv_pkg::OutW-1:0] rb_rx_reg;
    logic signed [pwsv_pkg::OutW-1:0] rb_ry_reg;

    pwsv_pkg::lane_ctl_t            ctl;
    logic [3:0]                     done;
    logic [pwsv_pkg::RootBits-1:0]  root [4];
    logic                           all_done;
    logic                           free_now;
    logic                           load;
    logic                           out_fire;

    function automatic logic signed [pwsv_pkg::OutW-1:0] apply_sign(
        input logic [pwsv_pkg::RootBits-1:0] v, input logic neg, input logic zero);
        logic signed [pwsv_pkg::OutW-1:0] m;
        m = $signed(pwsv_pkg::OutW'(v));
        if (zero)
            return '0;
        return neg ? -m : m;
    endfunction

    assign pop       = (state_reg == B_IDLE) && !stat.empty;
    assign all_done  = &done;
    assign out_fire  = splay.valid && splay.ready;
    assign free_now  = out_fire && (rb_cnt_reg == 2'd3);
    assign load      = (state_reg == B_RUN) && all_done && (!rb_valid_reg || free_now);
    assign ctl.start = pop;
    assign ctl.ack   = load;

    // lane 0: left x, 1: left y, 2: right x, 3: right y
    pwsv_lane u_lane_lx (.clk, .rst_n, .ctl, .span(rdata.left), .comp(rdata.ay),
                         .sq(rdata.sq), .done(done[0]), .root(root[0]));
    pwsv_lane u_lane_ly (.clk, .rst_n, .ctl, .span(rdata.left), .comp(rdata.ax),
                         .sq(rdata.sq), .done(done[1]), .root(root[1]));
    pwsv_lane u_lane_rx (.clk, .rst_n, .ctl, .span(rdata.right), .comp(rdata.ay),
                         .sq(rdata.sq), .done(done[2]), .root(root[2]));
    pwsv_lane u_lane_ry (.clk, .rst_n, .ctl, .span(rdata.right), .comp(rdata.ax),
                         .sq(rdata.sq), .done(done[3]), .root(root[3]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            neg_reg      <= '0;
            zero_reg     <= 1'b0;
            up_reg       <= '0;
            down_reg     <= '0;
            rb_valid_reg <= 1'b0;
            rb_cnt_reg   <= '0;
            rb_zero_reg  <= 1'b0;
            rb_up_reg    <= '0;
            rb_down_reg  <= '0;
            rb_lx_reg    <= '0;
            rb_ly_reg    <= '0;
            rb_rx_reg    <= '0;
            rb_ry_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                B_IDLE:
                begin
                    if (pop)
                    begin
                        neg_reg   <= {rdata.lx_neg, rdata.ly_neg, rdata.rx_neg, rdata.ry_neg};
                        zero_reg  <= rdata.zero;
                        up_reg    <= rdata.up;
                        down_reg  <= rdata.down;
                        state_reg <= B_RUN;
                    end
                end
                B_RUN:
                begin
                    if (load)
                        state_reg <= B_IDLE;
                end
                default:
                    state_reg <= B_IDLE;
            endcase

            if (load)
            begin
                rb_valid_reg <= 1'b1;
                rb_cnt_reg   <= '0;
                rb_zero_reg  <= zero_reg;
                rb_up_reg    <= up_reg;
                rb_down_reg  <= down_reg;
                rb_lx_reg    <= apply_sign(root[0], neg_reg[3], zero_reg);
                rb_ly_reg    <= apply_sign(root[1], neg_reg[2], zero_reg);
                rb_rx_reg    <= apply_sign(root[2], neg_reg[1], zero_reg);
                rb_ry_reg    <= apply_sign(root[3], neg_reg[0], zero_reg);
            end
            else if (out_fire)
            begin
                if (rb_cnt_reg == 2'd3)
                    rb_valid_reg <= 1'b0;
                rb_cnt_reg <= rb_cnt_reg + 2'd1;
            end
        end
    end

    always_comb
    begin
        splay.valid          = rb_valid_reg;
        splay.zero_direction = rb_zero_reg;
        splay.last           = (rb_cnt_reg == 2'd3);
        unique case (rb_cnt_reg)
            2'd0:
            begin
                splay.splay_kind = pwsv_pkg::KIND_UP;
                splay.splay_x    = '0;
                splay.splay_y    = '0;
                splay.splay_z    = $signed(pwsv_pkg::OutW'(rb_up_reg));
            end
            2'd1:
            begin
                splay.splay_kind = pwsv_pkg::KIND_DOWN;
                splay.splay_x    = '0;
                splay.splay_y    = '0;
                splay.splay_z    = -$signed(pwsv_pkg::OutW'(rb_down_reg));
            end
            2'd2:
            begin
                splay.splay_kind = pwsv_pkg::KIND_LEFT;
                splay.splay_x    = rb_lx_reg;
                splay.splay_y    = rb_ly_reg;
                splay.splay_z    = '0;
            end
            default:
            begin
                splay.splay_kind = pwsv_pkg::KIND_RIGHT;
                splay.splay_x    = rb_rx_reg;
                splay.splay_y    = rb_ry_reg;
                splay.splay_z    = '0;
            end
        endcase
    end

    `PWSV_ASSERT_IMP(a_lanes_agree, 1'b1, $countones(done) == 0 || $countones(done) == 4)
    `PWSV_ASSERT_NXT(a_load_fills, load, rb_valid_reg && rb_cnt_reg == 2'd0)

endmodule
